FILE: design/jlmp_pkg.sv
// ----------------------------------------------------------------------------
// jlmp_pkg
// Shared codes, constants and types of the jerk-limited motion profile.
// ----------------------------------------------------------------------------
`default_nettype none

package jlmp_pkg;

    // item operation codes
    localparam logic [1:0] OP_STEP   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // motion phases
    localparam logic [2:0] PH_HOLD    = 3'd0;
    localparam logic [2:0] PH_ACCEL   = 3'd1;
    localparam logic [2:0] PH_CRUISE  = 3'd2;
    localparam logic [2:0] PH_BRAKE   = 3'd3;
    localparam logic [2:0] PH_CAPTURE = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CAPTURE_WINDOW  = 3'd0;
    localparam logic [2:0] REG_CAPTURE_SPEED   = 3'd1;
    localparam logic [2:0] REG_SPEED_TOLERANCE = 3'd2;
    localparam logic [2:0] REG_BRAKE_RATE      = 3'd3;
    localparam logic [2:0] REG_DRIVE_RATE      = 3'd4;
    localparam logic [2:0] REG_SPEED_LIMIT     = 3'd5;
    localparam logic [2:0] REG_JERK_LIMIT      = 3'd6;
    localparam logic [2:0] REG_LEAD_TIME       = 3'd7;

    // braking distance saturation value, 2^40
    localparam logic [40:0] DIST_CAP = 41'h100_0000_0000;

    // iteration counts of the shared divide / root unit
    localparam logic [5:0] DIV_STEPS  = 6'd40;
    localparam logic [5:0] ROOT_STEPS = 6'd32;

    // command to the shared divide / root unit
    typedef struct packed {
        logic start;
        logic root_mode;
    } jlmp_iter_cmd_t;

endpackage

`default_nettype wire

FILE: design/jlmp_iter.sv
// ----------------------------------------------------------------------------
// jlmp_iter
// Shared shift-subtract unit: 64-bit integer square root (one result bit per
// cycle) or saturating 64/32 division capped at 2^40 (one quotient bit per
// cycle). Both modes use the same compare-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module jlmp_iter (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire jlmp_pkg::jlmp_iter_cmd_t cmd,
    input  wire  [63:0]                  operand,
    input  wire  [31:0]                  divisor,
    output logic                         done,
    output logic [40:0]                  result
);
    import jlmp_pkg::*;

    logic        busy_reg;
    logic        mode_reg;
    logic [5:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [40:0] acc_reg;
    logic [63:0] src_reg;
    logic [31:0] den_reg;

    logic [34:0] shifted;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    // shared compare-subtract
    always_comb begin
        if (mode_reg) begin
            shifted = {rem_reg[32:0], src_reg[63:62]};
            trial   = {1'b0, acc_reg[31:0], 2'b01};
        end else begin
            shifted = {rem_reg[33:0], src_reg[63]};
            trial   = {3'b000, den_reg};
        end
        diff = shifted - trial;
        ge   = (shifted >= trial);
    end

    assign done   = busy_reg && (cnt_reg == 6'd0);
    assign result = acc_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg <= cmd.root_mode;
            den_reg  <= divisor;
            rem_reg  <= '0;
            acc_reg  <= '0;
            src_reg  <= operand;
            if (cmd.root_mode) begin
                cnt_reg <= ROOT_STEPS;
            end else if (operand == 64'd0) begin
                cnt_reg <= 6'd0;
            end else if (divisor == 32'd0 || {8'd0, operand[63:40]} >= divisor) begin
                // quotient at or above the cap
                cnt_reg <= 6'd0;
                acc_reg <= DIST_CAP;
            end else begin
                cnt_reg <= DIV_STEPS;
                rem_reg <= {11'd0, operand[63:40]};
                src_reg <= {operand[39:0], 24'd0};
            end
        end else if (busy_reg && cnt_reg != 6'd0) begin
            rem_reg <= ge ? diff : shifted;
            acc_reg <= {acc_reg[39:0], ge};
            src_reg <= mode_reg ? {src_reg[61:0], 2'b00} : {src_reg[62:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

endmodule

`default_nettype wire

FILE: design/jerk_limited_motion_profile.sv
// ----------------------------------------------------------------------------
// jerk_limited_motion_profile
// One-axis jerk-limited motion profile in Q16.16 with look-ahead feedforward.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tuser: operation; tdata: position, velocity, time step
//  m_       | out       | tdata: target, position, velocity, accel, ff, phase
//  cfg_     | in        | register index and 31-bit value, always ready
//
//  Set target, reset state and no-op items go from idle straight to the output state.
//  A step runs one update (square root, one or two divisions on the shared unit,
//  up to six products on one 34x34 multiplier), then up to MAX_LEAD_STEPS
//  look-ahead updates. s_tready is high only while idle; a result held on a
//  stalled m_ channel delays the end of the following item only. Synchronous
//  reset loads defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module jerk_limited_motion_profile #(
    parameter int MAX_LEAD_STEPS     = 64,
    parameter int POSITION_TOLERANCE = 66
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [95:0]  s_tdata,   // position_value, velocity_value, time_step
    input  wire  [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [167:0] m_tdata,   // target_position, current_position,
                                    // current_velocity, current_accel,
                                    // feedforward_accel, motion_phase, zero pad
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [2:0]   cfg_index,
    input  wire  [30:0]  cfg_data
);
    import jlmp_pkg::*;

    localparam int LEAD_W = $clog2(MAX_LEAD_STEPS + 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_ADV_ERR   = 5'd1;
    localparam logic [4:0] S_ADV_PREP  = 5'd2;
    localparam logic [4:0] S_MUL_SQ    = 5'd3;
    localparam logic [4:0] S_SQRT_GO   = 5'd4;
    localparam logic [4:0] S_SQRT_WAIT = 5'd5;
    localparam logic [4:0] S_MUL_EX    = 5'd6;
    localparam logic [4:0] S_DIV1_GO   = 5'd7;
    localparam logic [4:0] S_DIV1_WAIT = 5'd8;
    localparam logic [4:0] S_MUL_BJ    = 5'd9;
    localparam logic [4:0] S_DIV2_GO   = 5'd10;
    localparam logic [4:0] S_DIV2_WAIT = 5'd11;
    localparam logic [4:0] S_DECIDE    = 5'd12;
    localparam logic [4:0] S_MUL_J     = 5'd13;
    localparam logic [4:0] S_SLEW      = 5'd14;
    localparam logic [4:0] S_MUL_V     = 5'd15;
    localparam logic [4:0] S_VEL       = 5'd16;
    localparam logic [4:0] S_MUL_P     = 5'd17;
    localparam logic [4:0] S_POS       = 5'd18;
    localparam logic [4:0] S_FINISH    = 5'd19;
    localparam logic [4:0] S_ADV_END   = 5'd20;
    localparam logic [4:0] S_LEAD_CHK  = 5'd21;
    localparam logic [4:0] S_DONE      = 5'd22;

    // configuration registers
    logic [30:0] cw_reg, cs_reg, st_tol_reg, br_reg, dr_reg, sl_reg, jl_reg, lt_reg;

    // architectural state
    logic signed [31:0] target_reg, position_reg, velocity_reg, accel_reg;
    logic signed [31:0] feedforward_reg;
    logic [2:0]         phase_reg;

    // working axis
    logic signed [31:0] work_tgt_reg, work_pos_reg, work_vel_reg, work_acc_reg;
    logic [2:0]         work_phase_reg;

    // sequencer and per-update temporaries
    logic [4:0]         fsm_reg;
    logic               ahead_reg;
    logic signed [31:0] dt_reg, step_reg;
    logic [30:0]        rem_reg;
    logic [LEAD_W-1:0]  n_reg;
    logic signed [32:0] err_reg, vt_reg;
    logic [31:0]        dist_reg, avail_reg;
    logic               neg_reg;
    logic [33:0]        bvel_reg;
    logic [41:0]        bd_reg;
    logic signed [31:0] desired_reg, a0_reg, v0_reg;
    logic signed [67:0] prod_reg;

    // output register
    logic               m_valid_reg;
    logic [167:0]       m_data_reg;

    // shared divide / root unit
    jlmp_iter_cmd_t     iter_cmd;
    logic [31:0]        iter_den;
    logic               iter_done;
    logic [40:0]        iter_res;

    jlmp_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iter_cmd),
        .operand (prod_reg[63:0]),
        .divisor (iter_den),
        .done    (iter_done),
        .result  (iter_res)
    );

    assign s_tready  = (fsm_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic signed [32:0] err_c, abs_err_c, vabs_c, vt_c, ex_c, dn_c;
    logic [31:0]        dist_c, avail_c, excess_c, absacc_c, cs_st_c;
    logic               snap_c;
    logic               c_win, c1, c2, c3, c4, cap_c, over_c;
    logic signed [31:0] brake_s, drive_s;
    logic [32:0]        bj_sum_c;
    logic signed [33:0] mul_a, mul_b;
    logic signed [49:0] a0w, tw, dw, up_w, dnw, nv_w, sl_w, pos_w;
    logic signed [31:0] slew_c, nv_c, pos_c;
    logic signed [31:0] lead_step_c;

    always_comb begin
        err_c     = {work_tgt_reg[31], work_tgt_reg} - {work_pos_reg[31], work_pos_reg};
        abs_err_c = err_reg[32] ? -err_reg : err_reg;
        dist_c    = abs_err_c[31:0];
        avail_c   = (dist_c > {1'b0, cw_reg}) ? dist_c - {1'b0, cw_reg} : 32'd0;
        vabs_c    = work_vel_reg[31] ? -{work_vel_reg[31], work_vel_reg}
                                     : {work_vel_reg[31], work_vel_reg};
        vt_c      = err_reg[32] ? -{work_vel_reg[31], work_vel_reg}
                                : {work_vel_reg[31], work_vel_reg};
        snap_c    = (dist_c <= 32'(POSITION_TOLERANCE)) &&
                    ($unsigned(vabs_c) <= {2'b00, st_tol_reg});
        cs_st_c   = {1'b0, cs_reg} + {1'b0, st_tol_reg};

        ex_c      = vt_reg - $signed({2'b00, cs_reg});
        excess_c  = ex_c[32] ? 32'd0 : ex_c[31:0];
        absacc_c  = work_acc_reg[31] ? 32'(-work_acc_reg) : work_acc_reg;
        bj_sum_c  = {1'b0, absacc_c} + {2'b00, br_reg};

        // phase decision
        brake_s = $signed({1'b0, br_reg});
        drive_s = $signed({1'b0, dr_reg});
        c_win   = dist_reg <= {1'b0, cw_reg};
        c1      = c_win && !vt_reg[32] && (vt_reg <= $signed({1'b0, cs_st_c}));
        c2      = vt_reg < -$signed({2'b00, st_tol_reg});
        c3      = ($signed({{2{vt_reg[32]}}, vt_reg}) >= $signed({1'b0, bvel_reg})) ||
                  (bd_reg >= {10'd0, avail_reg});
        c4      = vt_reg >= $signed({2'b00, sl_reg});

        // acceleration slew toward the desired value
        a0w  = {{18{work_acc_reg[31]}}, work_acc_reg};
        tw   = {{18{desired_reg[31]}}, desired_reg};
        dw   = {3'b000, prod_reg[62:16]};
        up_w = a0w + dw;
        dnw  = a0w - dw;
        if (a0w < tw) begin
            slew_c = (up_w > tw) ? desired_reg : up_w[31:0];
        end else begin
            slew_c = (dnw < tw) ? desired_reg : dnw[31:0];
        end

        // velocity update with clamp
        sl_w = {19'd0, sl_reg};
        nv_w = {{18{work_vel_reg[31]}}, work_vel_reg} +
               {{2{prod_reg[64]}}, prod_reg[64:17]};
        if (nv_w > sl_w) begin
            nv_c = {1'b0, sl_reg};
        end else if (nv_w < -sl_w) begin
            nv_c = -$signed({1'b0, sl_reg});
        end else begin
            nv_c = nv_w[31:0];
        end

        // position update with saturation
        pos_w = {{18{work_pos_reg[31]}}, work_pos_reg} +
                {{2{prod_reg[64]}}, prod_reg[64:17]};
        if (pos_w > 50'sh0_0000_7FFF_FFFF) begin
            pos_c = 32'sh7FFF_FFFF;
        end else if (pos_w < -50'sh0_0000_8000_0000) begin
            pos_c = -32'sh8000_0000;
        end else begin
            pos_c = pos_w[31:0];
        end

        // capture and overshoot tests on the updated axis
        dn_c   = neg_reg ? -{work_vel_reg[31], work_vel_reg}
                         : {work_vel_reg[31], work_vel_reg};
        cap_c  = c_win && !dn_c[32] && (dn_c <= $signed({1'b0, cs_st_c})) &&
                 (work_acc_reg == 32'sd0);
        over_c = (!neg_reg && err_reg != 33'sd0 && work_pos_reg >= work_tgt_reg) ||
                 (neg_reg && work_pos_reg <= work_tgt_reg);

        lead_step_c = ($signed({1'b0, rem_reg}) < dt_reg) ? $signed({1'b0, rem_reg})
                                                          : dt_reg;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (fsm_reg)
            S_MUL_SQ: begin
                mul_a = {2'b00, br_reg, 1'b0};
                mul_b = {2'b00, avail_reg};
            end
            S_MUL_EX: begin
                mul_a = {2'b00, excess_c};
                mul_b = {2'b00, excess_c};
            end
            S_MUL_BJ: begin
                mul_a = {vt_reg[32], vt_reg};
                mul_b = {1'b0, bj_sum_c};
            end
            S_MUL_J: begin
                mul_a = {3'b000, jl_reg};
                mul_b = {{2{step_reg[31]}}, step_reg};
            end
            S_MUL_V: begin
                mul_a = {{2{a0_reg[31]}}, a0_reg} + {{2{work_acc_reg[31]}}, work_acc_reg};
                mul_b = {{2{step_reg[31]}}, step_reg};
            end
            S_MUL_P: begin
                mul_a = {{2{v0_reg[31]}}, v0_reg} + {{2{work_vel_reg[31]}}, work_vel_reg};
                mul_b = {{2{step_reg[31]}}, step_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divide / root unit commands
    always_comb begin
        iter_cmd.start     = (fsm_reg == S_SQRT_GO) || (fsm_reg == S_DIV1_GO) ||
                             (fsm_reg == S_DIV2_GO);
        iter_cmd.root_mode = (fsm_reg == S_SQRT_GO);
        iter_den           = (fsm_reg == S_DIV2_GO) ? {1'b0, jl_reg} : {br_reg, 1'b0};
    end

    // multiplier output register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg     <= 31'd655;
            cs_reg     <= 31'd3277;
            st_tol_reg <= 31'd66;
            br_reg     <= 31'd65536;
            dr_reg     <= 31'd65536;
            sl_reg     <= 31'd32768;
            jl_reg     <= 31'd655360;
            lt_reg     <= 31'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CAPTURE_WINDOW:  cw_reg     <= cfg_data;
                REG_CAPTURE_SPEED:   cs_reg     <= cfg_data;
                REG_SPEED_TOLERANCE: st_tol_reg <= cfg_data;
                REG_BRAKE_RATE:      br_reg     <= cfg_data;
                REG_DRIVE_RATE:      dr_reg     <= cfg_data;
                REG_SPEED_LIMIT:     sl_reg     <= cfg_data;
                REG_JERK_LIMIT:      jl_reg     <= cfg_data;
                REG_LEAD_TIME:       lt_reg     <= cfg_data;
                default:             cw_reg     <= cw_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg         <= S_IDLE;
            m_valid_reg     <= 1'b0;
            target_reg      <= '0;
            position_reg    <= '0;
            velocity_reg    <= '0;
            accel_reg       <= '0;
            feedforward_reg <= '0;
            phase_reg       <= PH_HOLD;
            ahead_reg       <= 1'b0;
        end else begin
            // result taken; S_DONE handles the output register itself
            if (m_valid_reg && m_tready && fsm_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        fsm_reg <= S_DONE;
                        if (s_tuser == OP_RESET) begin
                            target_reg      <= s_tdata[31:0];
                            position_reg    <= s_tdata[31:0];
                            velocity_reg    <= s_tdata[63:32];
                            accel_reg       <= '0;
                            feedforward_reg <= '0;
                            phase_reg       <= PH_HOLD;
                        end else if (s_tuser == OP_TARGET) begin
                            target_reg <= s_tdata[31:0];
                        end else if (s_tuser == OP_STEP && !s_tdata[95] &&
                                     s_tdata[94:64] != 31'd0) begin
                            work_tgt_reg   <= target_reg;
                            work_pos_reg   <= position_reg;
                            work_vel_reg   <= velocity_reg;
                            work_acc_reg   <= accel_reg;
                            work_phase_reg <= phase_reg;
                            dt_reg         <= s_tdata[95:64];
                            step_reg       <= s_tdata[95:64];
                            ahead_reg      <= 1'b0;
                            fsm_reg        <= S_ADV_ERR;
                        end
                    end
                end
                S_ADV_ERR: begin
                    err_reg <= err_c;
                    fsm_reg <= S_ADV_PREP;
                end
                S_ADV_PREP: begin
                    dist_reg  <= dist_c;
                    neg_reg   <= err_reg[32];
                    vt_reg    <= vt_c;
                    avail_reg <= avail_c;
                    if (snap_c) begin
                        work_pos_reg   <= work_tgt_reg;
                        work_vel_reg   <= '0;
                        work_acc_reg   <= '0;
                        work_phase_reg <= PH_HOLD;
                        fsm_reg        <= S_ADV_END;
                    end else begin
                        fsm_reg <= S_MUL_SQ;
                    end
                end
                S_MUL_SQ:  fsm_reg <= S_SQRT_GO;
                S_SQRT_GO: fsm_reg <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (iter_done) begin
                        bvel_reg <= {3'b000, cs_reg} + {2'b00, iter_res[31:0]};
                        fsm_reg  <= S_MUL_EX;
                    end
                end
                S_MUL_EX:  fsm_reg <= S_DIV1_GO;
                S_DIV1_GO: fsm_reg <= S_DIV1_WAIT;
                S_DIV1_WAIT: begin
                    if (iter_done) begin
                        bd_reg  <= {1'b0, iter_res};
                        fsm_reg <= (!vt_reg[32] && vt_reg != 33'sd0) ? S_MUL_BJ : S_DECIDE;
                    end
                end
                S_MUL_BJ:  fsm_reg <= S_DIV2_GO;
                S_DIV2_GO: fsm_reg <= S_DIV2_WAIT;
                S_DIV2_WAIT: begin
                    if (iter_done) begin
                        bd_reg  <= bd_reg + {1'b0, iter_res};
                        fsm_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (c1) begin
                        desired_reg    <= '0;
                        work_phase_reg <= PH_BRAKE;
                    end else if (c2) begin
                        desired_reg    <= neg_reg ? -brake_s : brake_s;
                        work_phase_reg <= PH_BRAKE;
                    end else if (c3) begin
                        desired_reg    <= neg_reg ? brake_s : -brake_s;
                        work_phase_reg <= PH_BRAKE;
                    end else if (c4) begin
                        desired_reg    <= '0;
                        work_phase_reg <= PH_CRUISE;
                    end else begin
                        desired_reg    <= neg_reg ? -drive_s : drive_s;
                        work_phase_reg <= PH_ACCEL;
                    end
                    fsm_reg <= S_MUL_J;
                end
                S_MUL_J: fsm_reg <= S_SLEW;
                S_SLEW: begin
                    a0_reg       <= work_acc_reg;
                    work_acc_reg <= slew_c;
                    fsm_reg      <= S_MUL_V;
                end
                S_MUL_V: fsm_reg <= S_VEL;
                S_VEL: begin
                    v0_reg       <= work_vel_reg;
                    work_vel_reg <= nv_c;
                    fsm_reg      <= S_MUL_P;
                end
                S_MUL_P: fsm_reg <= S_POS;
                S_POS: begin
                    work_pos_reg <= pos_c;
                    fsm_reg      <= S_FINISH;
                end
                S_FINISH: begin
                    if (cap_c) begin
                        work_phase_reg <= PH_CAPTURE;
                    end else if (over_c) begin
                        work_pos_reg   <= work_tgt_reg;
                        work_vel_reg   <= '0;
                        work_acc_reg   <= '0;
                        work_phase_reg <= PH_HOLD;
                    end
                    fsm_reg <= S_ADV_END;
                end
                S_ADV_END: begin
                    if (!ahead_reg) begin
                        // main update done: commit, then start the look-ahead
                        position_reg <= work_pos_reg;
                        velocity_reg <= work_vel_reg;
                        accel_reg    <= work_acc_reg;
                        phase_reg    <= work_phase_reg;
                        rem_reg      <= lt_reg;
                        n_reg        <= '0;
                        ahead_reg    <= 1'b1;
                    end else begin
                        rem_reg <= rem_reg - step_reg[30:0];
                        n_reg   <= n_reg + LEAD_W'(1);
                    end
                    fsm_reg <= S_LEAD_CHK;
                end
                S_LEAD_CHK: begin
                    if (rem_reg != 31'd0 && work_phase_reg != PH_HOLD &&
                        work_phase_reg != PH_CAPTURE &&
                        n_reg < LEAD_W'(MAX_LEAD_STEPS)) begin
                        step_reg <= lead_step_c;
                        fsm_reg  <= S_ADV_ERR;
                    end else begin
                        feedforward_reg <= work_acc_reg;
                        fsm_reg         <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'd0, phase_reg, feedforward_reg, accel_reg,
                                        velocity_reg, position_reg, target_reg};
                        fsm_reg     <= S_IDLE;
                    end
                end
                default: fsm_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the jerk-limited motion profile. Items go in on the
// s_ stream with random bursts and gaps, and results come back on m_ under a
// stall pattern. A scoreboard predicts every result in 64-bit fixed point and
// compares it with the block's output. The run goes through several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import jlmp_pkg::*;

    localparam int          LEAD_STEP_MAX = 64;
    localparam longint      POS_TOL       = 66;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam longint      CAP           = 64'd1 << 40;
    localparam logic [30:0] R_MAX         = 31'h7fff_ffff;

    typedef struct {
        longint tgt;
        longint pos;
        longint vel;
        longint acc;
        logic [2:0] phase;
    } axis_t;

    typedef struct {
        logic [31:0] tgt;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [31:0] ff;
        logic [2:0]  phase;
    } profile_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: profile predictor plus queue of expected results
    // ------------------------------------------------------------------------
    class profile_scoreboard;
        longint cw, cs, stol, br, dr, slim, jl, lead;
        axis_t  st;
        longint ff;
        int     errors;
        profile_result_t expected_results[$];

        function new();
            cw = 655; cs = 3277; stol = 66; br = 65536; dr = 65536;
            slim = 32768; jl = 655360; lead = 0;
            st = '{0, 0, 0, 0, PH_HOLD};
            ff = 0;
            errors = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [30:0] val);
            longint v;
            v = longint'({33'd0, val});
            case (idx)
                REG_CAPTURE_WINDOW:  cw = v;
                REG_CAPTURE_SPEED:   cs = v;
                REG_SPEED_TOLERANCE: stol = v;
                REG_BRAKE_RATE:      br = v;
                REG_DRIVE_RATE:      dr = v;
                REG_SPEED_LIMIT:     slim = v;
                REG_JERK_LIMIT:      jl = v;
                REG_LEAD_TIME:       lead = v;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned capped_quot(longint unsigned num, longint unsigned den);
            longint unsigned q;
            if (num == 0) return 0;
            if (den == 0) return CAP;
            q = num / den;
            return (q > CAP) ? CAP : q;
        endfunction

        function longint slew(longint v, longint t, longint d);
            if (v < t) return (v + d > t) ? t : v + d;
            return (v - d < t) ? t : v - d;
        endfunction

        function void park(inout axis_t a);
            a.pos = a.tgt;
            a.vel = 0;
            a.acc = 0;
            a.phase = PH_HOLD;
        endfunction

        // one profile update over time step dt
        function void advance_axis(inout axis_t a, input longint dt);
            longint err, span, dir, vt, avail, bvel, excess, desired, a0, v0, nv, absacc;
            longint unsigned bdist;
            err = a.tgt - a.pos;
            span = (err < 0) ? -err : err;
            dir = (err >= 0) ? 1 : -1;
            vt = dir * a.vel;
            avail = span - cw;
            if (span <= POS_TOL && ((a.vel < 0) ? -a.vel : a.vel) <= stol) begin
                park(a);
                return;
            end
            if (avail < 0) avail = 0;
            bvel = cs + longint'(root_floor(2 * br * avail));
            excess = vt - cs;
            if (excess < 0) excess = 0;
            bdist = capped_quot(excess * excess, 2 * br);
            absacc = (a.acc < 0) ? -a.acc : a.acc;
            if (vt > 0)
                bdist += capped_quot(vt * (absacc + br), jl);

            if (span <= cw && vt >= 0 && vt <= cs + stol) begin
                desired = 0; a.phase = PH_BRAKE;
            end else if (vt < -stol) begin
                desired = dir * br; a.phase = PH_BRAKE;
            end else if (vt >= bvel || bdist >= longint'(avail)) begin
                desired = -dir * br; a.phase = PH_BRAKE;
            end else if (vt >= slim) begin
                desired = 0; a.phase = PH_CRUISE;
            end else begin
                desired = dir * dr; a.phase = PH_ACCEL;
            end

            a0 = a.acc;
            a.acc = slew(a0, desired, (jl * dt) >>> 16);
            v0 = a.vel;
            nv = a.vel + (((a0 + a.acc) * dt) >>> 17);
            if (nv > slim) nv = slim;
            if (nv < -slim) nv = -slim;
            a.vel = nv;
            a.pos += ((v0 + nv) * dt) >>> 17;
            if (a.pos > 64'sd2147483647) a.pos = 64'sd2147483647;
            if (a.pos < -64'sd2147483648) a.pos = -64'sd2147483648;

            if (span <= cw && dir * nv >= 0 && dir * nv <= cs + stol && a.acc == 0) begin
                a.phase = PH_CAPTURE;
                return;
            end
            if ((err > 0 && a.pos >= a.tgt) || (err < 0 && a.pos <= a.tgt))
                park(a);
        endfunction

        // accepted input item: update the model and queue the expected result
        function void note_item(logic [1:0] op, logic [31:0] pv, logic [31:0] vv,
                                logic [31:0] dtv);
            axis_t ahead;
            longint dt, rem, sub;
            int n;
            profile_result_t r;
            dt = longint'(signed'(dtv));
            if (op == OP_RESET) begin
                st = '{longint'(signed'(pv)), longint'(signed'(pv)),
                       longint'(signed'(vv)), 0, PH_HOLD};
                ff = 0;
            end else if (op == OP_TARGET) begin
                st.tgt = longint'(signed'(pv));
            end else if (op == OP_STEP && dt > 0) begin
                advance_axis(st, dt);
                ahead = st;
                rem = lead;
                n = 0;
                while (rem > 0 && ahead.phase != PH_HOLD && ahead.phase != PH_CAPTURE &&
                       n < LEAD_STEP_MAX) begin
                    sub = (rem < dt) ? rem : dt;
                    advance_axis(ahead, sub);
                    rem -= sub;
                    n++;
                end
                ff = ahead.acc;
            end
            r.tgt = st.tgt[31:0];
            r.pos = st.pos[31:0];
            r.vel = st.vel[31:0];
            r.acc = st.acc[31:0];
            r.ff = ff[31:0];
            r.phase = st.phase;
            expected_results.push_back(r);
        endfunction

        function void report(string name, logic [31:0] exp_v, logic [31:0] act_v);
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        endfunction

        function void check_result(logic [167:0] d);
            profile_result_t e;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (d[31:0] !== e.tgt)    report("target_position", e.tgt, d[31:0]);
            if (d[63:32] !== e.pos)   report("current_position", e.pos, d[63:32]);
            if (d[95:64] !== e.vel)   report("current_velocity", e.vel, d[95:64]);
            if (d[127:96] !== e.acc)  report("current_accel", e.acc, d[127:96]);
            if (d[159:128] !== e.ff)  report("feedforward_accel", e.ff, d[159:128]);
            if (d[162:160] !== e.phase)
                report("motion_phase", {29'd0, e.phase}, {29'd0, d[162:160]});
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;

    profile_scoreboard sb;
    int  burst_left;
    bit  long_hold;

    jerk_limited_motion_profile u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watch both handshakes
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: stall pattern in three random modes, one long hold on request
    initial begin
        int cyc, mode;
        cyc = 0;
        mode = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                cyc++;
            end
        end
    end

    initial begin
        #60_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // offer one item; keeps valid high while the burst lasts
    task automatic send_item(logic [1:0] op, logic [31:0] pv, logic [31:0] vv,
                             logic [31:0] dt);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {dt, vv, pv};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [30:0] cw, logic [30:0] cs, logic [30:0] stol,
                           logic [30:0] br, logic [30:0] dr, logic [30:0] sl,
                           logic [30:0] jl, logic [30:0] lt);
        write_register(REG_CAPTURE_WINDOW, cw);
        write_register(REG_CAPTURE_SPEED, cs);
        write_register(REG_SPEED_TOLERANCE, stol);
        write_register(REG_BRAKE_RATE, br);
        write_register(REG_DRIVE_RATE, dr);
        write_register(REG_SPEED_LIMIT, sl);
        write_register(REG_JERK_LIMIT, jl);
        write_register(REG_LEAD_TIME, lt);
        @(posedge aclk);
    endtask

    // random traffic: mostly move sequences, some noise; count effective items
    task automatic random_moves(int count);
        int done_cnt, r;
        logic [31:0] base;
        done_cnt = 0;
        while (done_cnt < count) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                base = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                send_item(OP_RESET, base, $urandom_range(0, 65536) - 32768, $urandom());
                done_cnt++;
            end else if (r < 14) begin
                send_item(OP_TARGET, sb.st.pos[31:0] + $urandom_range(0, 32'h0008_0000)
                          - 32'h0004_0000, $urandom(), $urandom());
                done_cnt++;
            end else if (r < 80) begin
                send_item(OP_STEP, $urandom(), $urandom(), $urandom_range(65, 6554));
                done_cnt++;
            end else if (r < 85) begin
                send_item(OP_STEP, $urandom(), $urandom(), -$urandom_range(0, 32'h7fff_ffff));
            end else if (r < 88) begin
                send_item(OP_UNUSED, $urandom(), $urandom(), $urandom());
            end else begin
                send_item(2'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom());
                done_cnt++;
            end
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        long_hold = 1'b0;
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_STEP;
        cfg_valid = 1'b0;
        cfg_index = REG_CAPTURE_WINDOW;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, field extremes, every operation, corner cases
        set_all(655, 3277, 66, 65536, 65536, 32768, 655360, 0);
        send_item(OP_STEP, 0, 0, 655);
        send_item(OP_TARGET, 32'h0001_0000, 0, 0);
        repeat (6) send_item(OP_STEP, 0, 0, 6554);
        send_item(OP_STEP, 0, 0, 0);
        send_item(OP_STEP, 0, 0, 32'h8000_0000);
        send_item(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_RESET, 32'h7fff_0000, 32'h7fff_ffff, 0);
        send_item(OP_TARGET, 32'h7fff_ffff, 0, 0);
        send_item(OP_STEP, 0, 0, 32'h7fff_ffff);
        send_item(OP_RESET, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(OP_TARGET, 32'h8000_0000, 0, 0);
        send_item(OP_STEP, 0, 0, 1);
        send_item(OP_TARGET, 32'h7fff_ffff, 0, 0);
        send_item(OP_STEP, 0, 0, 6554);
        send_item(OP_RESET, 0, 0, 0);
        send_item(OP_TARGET, 300, 0, 0);
        send_item(OP_STEP, 0, 0, 655);
        wait_drained();
        random_moves(40);
        wait_drained();

        // extremes: all registers at maximum, then all at zero
        set_all(R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX, R_MAX);
        random_moves(25);
        wait_drained();
        set_all(0, 0, 0, 0, 0, 0, 0, 0);
        random_moves(25);
        wait_drained();

        // short look-ahead; receiver holds off once while items keep coming
        set_all(1310, 6554, 33, 131072, 98304, 65536, 1310720, 655);
        long_hold = 1'b1;
        random_moves(70);
        wait_drained();

        // look-ahead longer than the sub-step cap
        set_all(655, 3277, 66, 65536, 65536, 32768, 655360, R_MAX);
        random_moves(15);
        wait_drained();

        // full-range random registers
        set_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom_range(0, 65536));
        random_moves(40);
        wait_drained();
        set_all($urandom_range(0, 2000), $urandom_range(0, 8000), $urandom_range(0, 200),
                $urandom_range(1000, 400000), $urandom_range(1000, 400000),
                $urandom_range(1000, 200000), $urandom_range(0, 4000000),
                $urandom_range(0, 20000));
        random_moves(70);
        wait_drained();

        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
